@@ src/cursor_linked_list_engine_core_defines.svh @@
// ----------------------------------------------------------------------------
// cursor linked list engine assertion macros
// shared property forms for the engine's internal checks
// ----------------------------------------------------------------------------
`ifndef CURSOR_LINKED_LIST_ENGINE_CORE_DEFINES_SVH
`define CURSOR_LINKED_LIST_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CLLE_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clle assertion failed");

// next-cycle implication
`define CLLE_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clle assertion failed");

`else

`define CLLE_ASSERT_IMP(name, clk, rst, ante, cons)
`define CLLE_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

@@ src/clle_pkg.sv @@
// ----------------------------------------------------------------------------
// clle_pkg
// sizes, codes, types and helpers of the cursor linked list engine
// ----------------------------------------------------------------------------
package clle_pkg;

   localparam int NODES       = 16;
   localparam int DATA_BITS   = 32;
   localparam int IDX_BITS    = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int NODE_BITS   = 4;
   localparam int VALUE_BITS  = 32;
   localparam int OP_BITS     = 3;
   localparam int STATUS_BITS = 2;

   localparam logic [OP_BITS-1:0] OP_NEW_LIST = 3'd0;
   localparam logic [OP_BITS-1:0] OP_INSERT   = 3'd1;
   localparam logic [OP_BITS-1:0] OP_DELETE   = 3'd2;
   localparam logic [OP_BITS-1:0] OP_FIND     = 3'd3;
   localparam logic [OP_BITS-1:0] OP_IS_EMPTY = 3'd4;
   localparam logic [OP_BITS-1:0] OP_IS_LAST  = 3'd5;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_POOL_OUT  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_INDEX = 2'd2;

   typedef struct packed {
      logic [OP_BITS-1:0]          operation;
      logic signed [VALUE_BITS-1:0] value;
      logic [NODE_BITS-1:0]        list_head;
      logic [NODE_BITS-1:0]        position;
   } req_type;

   typedef struct packed {
      logic [NODE_BITS-1:0]   node_index;
      logic                   flag;
      logic [STATUS_BITS-1:0] status;
   } res_type;

   // sign extend, then keep the low data bits
   function automatic logic [DATA_BITS-1:0] to_data(input logic signed [VALUE_BITS-1:0] x);
      return DATA_BITS'(x);
   endfunction

   function automatic logic is_bad_index(input logic [NODE_BITS-1:0] idx);
      return (idx == '0) || (32'(idx) >= 32'(NODES));
   endfunction

endpackage

@@ src/cursor_linked_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_core
// singly linked lists in a shared node pool with a free chain at node 0
// ----------------------------------------------------------------------------
// After reset the link memory is swept, one entry a cycle, to build the free
// chain; no item is taken during the sweep. Links live in a one-read-port
// memory and elements in a second one, both read through a register. Errors
// go straight to the result; is_empty and is_last read one link; new_list
// reads and clears its node's link; insert reads two links, then writes two
// and the element; find and delete walk the list one link at a time (at most
// NODES links), delete adding a write-back when it removes a node; the walk
// is bound by the single link read port. One item is worked on at a time; the
// next is taken while the previous result waits in the output register.
module cursor_linked_list_engine_core import clle_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_BITS-1:0]     req_operation,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic [NODE_BITS-1:0]   req_list_head,
   input  logic [NODE_BITS-1:0]   req_position,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [NODE_BITS-1:0]   rsp_node_index,
   output logic                   rsp_flag,
   output logic [STATUS_BITS-1:0] rsp_status
);

   req_type              req;
   res_type              res;
   logic                 res_valid;
   logic                 res_taken;
   logic                 link_we;
   logic [IDX_BITS-1:0]  link_waddr, link_wdata, link_raddr, link_rdata;
   logic                 elem_we;
   logic [IDX_BITS-1:0]  elem_waddr, elem_raddr;
   logic [DATA_BITS-1:0] elem_wdata, elem_rdata;

   assign req = '{operation: req_operation, value: req_value,
                  list_head: req_list_head, position: req_position};

   clle_ram #(
      .WIDTH (IDX_BITS),
      .DEPTH (NODES)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

   clle_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (NODES)
   ) u_elem_ram (
      .clock (clock),
      .we    (elem_we),
      .waddr (elem_waddr),
      .wdata (elem_wdata),
      .raddr (elem_raddr),
      .rdata (elem_rdata)
   );

   clle_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req        (req),
      .req_stall  (req_stall),
      .res_valid  (res_valid),
      .res        (res),
      .res_taken  (res_taken),
      .link_we    (link_we),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .link_raddr (link_raddr),
      .link_rdata (link_rdata),
      .elem_we    (elem_we),
      .elem_waddr (elem_waddr),
      .elem_wdata (elem_wdata),
      .elem_raddr (elem_raddr),
      .elem_rdata (elem_rdata)
   );

   clle_out u_out (
      .clock          (clock),
      .reset          (reset),
      .res_valid      (res_valid),
      .res            (res),
      .res_taken      (res_taken),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_node_index (rsp_node_index),
      .rsp_flag       (rsp_flag),
      .rsp_status     (rsp_status)
   );

endmodule

@@ src/clle_ram.sv @@
// ----------------------------------------------------------------------------
// clle_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module clle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/clle_seq.sv @@
// ----------------------------------------------------------------------------
// clle_seq
// operation sequencer: walks and rewrites the link and element memories
// ----------------------------------------------------------------------------
`include "cursor_linked_list_engine_core_defines.svh"

module clle_seq import clle_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  req_type              req,
   output logic                 req_stall,
   output logic                 res_valid,
   output res_type              res,
   input  logic                 res_taken,
   output logic                 link_we,
   output logic [IDX_BITS-1:0]  link_waddr,
   output logic [IDX_BITS-1:0]  link_wdata,
   output logic [IDX_BITS-1:0]  link_raddr,
   input  logic [IDX_BITS-1:0]  link_rdata,
   output logic                 elem_we,
   output logic [IDX_BITS-1:0]  elem_waddr,
   output logic [DATA_BITS-1:0] elem_wdata,
   output logic [IDX_BITS-1:0]  elem_raddr,
   input  logic [DATA_BITS-1:0] elem_rdata
);

   localparam logic [3:0] ST_INIT       = 4'd0;
   localparam logic [3:0] ST_IDLE       = 4'd1;
   localparam logic [3:0] ST_NEW_RD     = 4'd2;
   localparam logic [3:0] ST_NEW_WR     = 4'd3;
   localparam logic [3:0] ST_INS_RD_POS = 4'd4;
   localparam logic [3:0] ST_INS_RD_FRE = 4'd5;
   localparam logic [3:0] ST_INS_WR_POS = 4'd6;
   localparam logic [3:0] ST_INS_WR_NOD = 4'd7;
   localparam logic [3:0] ST_DEL_RD     = 4'd8;
   localparam logic [3:0] ST_DEL_CHK    = 4'd9;
   localparam logic [3:0] ST_DEL_CMP    = 4'd10;
   localparam logic [3:0] ST_DEL_WR     = 4'd11;
   localparam logic [3:0] ST_FND_RD     = 4'd12;
   localparam logic [3:0] ST_FND_CHK    = 4'd13;
   localparam logic [3:0] ST_FND_CMP    = 4'd14;
   localparam logic [3:0] ST_RESP       = 4'd15;

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NODES - 1);

   logic [3:0]           state_ff, state_in;
   logic [IDX_BITS-1:0]  free_ff, free_in;
   logic [IDX_BITS-1:0]  init_ff, init_in;
   logic [IDX_BITS-1:0]  addr_ff, addr_in;
   logic [IDX_BITS-1:0]  node_ff, node_in;
   logic [IDX_BITS-1:0]  p_ff, p_in;
   logic [IDX_BITS-1:0]  t_ff, t_in;
   logic [IDX_BITS-1:0]  k_ff, k_in;
   logic [IDX_BITS-1:0]  after_ff, after_in;
   logic [DATA_BITS-1:0] value_ff, value_in;
   logic                 test_ff, test_in;
   res_type              res_ff, res_in;
   logic [IDX_BITS-1:0]  head_idx, pos_idx;
   logic                 elem_match;

   function automatic res_type make_res(input logic [IDX_BITS-1:0] n, input logic f,
                                        input logic [STATUS_BITS-1:0] s);
      return '{node_index: NODE_BITS'(n), flag: f, status: s};
   endfunction

   assign head_idx   = IDX_BITS'(req.list_head);
   assign pos_idx    = IDX_BITS'(req.position);
   assign elem_match = (elem_rdata == value_ff);

   always_comb begin
      state_in   = state_ff;
      free_in    = free_ff;
      init_in    = init_ff;
      addr_in    = addr_ff;
      node_in    = node_ff;
      p_in       = p_ff;
      t_in       = t_ff;
      k_in       = k_ff;
      after_in   = after_ff;
      value_in   = value_ff;
      test_in    = test_ff;
      res_in     = res_ff;
      link_we    = 1'b0;
      link_waddr = addr_ff;
      link_wdata = '0;
      link_raddr = addr_ff;
      elem_we    = 1'b0;

      case (state_ff)
         ST_INIT: begin
            link_we    = 1'b1;
            link_waddr = init_ff;
            link_wdata = (init_ff == LAST_IDX) ? '0 : IDX_BITS'(init_ff + 1'b1);
            init_in    = IDX_BITS'(init_ff + 1'b1);
            if (init_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               value_in = to_data(req.value);
               node_in  = free_ff;
               p_in     = head_idx;
               case (req.operation)
                  OP_NEW_LIST: begin
                     if (free_ff == '0) begin
                        res_in   = make_res('0, 1'b0, STATUS_POOL_OUT);
                        state_in = ST_RESP;
                     end else begin
                        state_in = ST_NEW_RD;
                     end
                  end
                  OP_INSERT: begin
                     addr_in = pos_idx;
                     if (is_bad_index(req.position)) begin
                        res_in   = make_res('0, 1'b0, STATUS_BAD_INDEX);
                        state_in = ST_RESP;
                     end else if (free_ff == '0) begin
                        res_in   = make_res('0, 1'b0, STATUS_POOL_OUT);
                        state_in = ST_RESP;
                     end else begin
                        state_in = ST_INS_RD_POS;
                     end
                  end
                  OP_DELETE, OP_FIND, OP_IS_EMPTY: begin
                     addr_in = head_idx;
                     if (is_bad_index(req.list_head)) begin
                        res_in   = make_res('0, 1'b0, STATUS_BAD_INDEX);
                        state_in = ST_RESP;
                     end else if (req.operation == OP_DELETE) begin
                        state_in = ST_DEL_RD;
                     end else begin
                        test_in  = (req.operation == OP_IS_EMPTY);
                        state_in = ST_FND_RD;
                     end
                  end
                  OP_IS_LAST: begin
                     addr_in = pos_idx;
                     if (is_bad_index(req.position)) begin
                        res_in   = make_res('0, 1'b0, STATUS_BAD_INDEX);
                        state_in = ST_RESP;
                     end else begin
                        test_in  = 1'b1;
                        state_in = ST_FND_RD;
                     end
                  end
                  default: begin
                     res_in   = make_res('0, 1'b0, STATUS_OK);
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_NEW_RD: begin
            link_raddr = node_ff;
            state_in   = ST_NEW_WR;
         end
         ST_NEW_WR: begin
            free_in    = link_rdata;
            link_we    = 1'b1;
            link_waddr = node_ff;
            link_wdata = '0;
            res_in     = make_res(node_ff, 1'b0, STATUS_OK);
            state_in   = ST_RESP;
         end
         ST_INS_RD_POS: begin
            link_raddr = addr_ff;
            state_in   = ST_INS_RD_FRE;
         end
         ST_INS_RD_FRE: begin
            after_in   = link_rdata;
            link_raddr = node_ff;
            state_in   = ST_INS_WR_POS;
         end
         ST_INS_WR_POS: begin
            free_in    = link_rdata;
            link_we    = 1'b1;
            link_waddr = addr_ff;
            link_wdata = node_ff;
            elem_we    = 1'b1;
            state_in   = ST_INS_WR_NOD;
         end
         ST_INS_WR_NOD: begin
            link_we    = 1'b1;
            link_waddr = node_ff;
            link_wdata = after_ff;
            res_in     = make_res(node_ff, 1'b0, STATUS_OK);
            state_in   = ST_RESP;
         end
         ST_DEL_RD: begin
            link_raddr = addr_ff;
            state_in   = ST_DEL_CHK;
         end
         ST_DEL_CHK: begin
            // reads of the first candidate go out at its index
            link_raddr = link_rdata;
            t_in       = link_rdata;
            k_in       = '0;
            if (link_rdata == '0) begin
               res_in   = make_res('0, 1'b0, STATUS_OK);
               state_in = ST_RESP;
            end else begin
               state_in = ST_DEL_CMP;
            end
         end
         ST_DEL_CMP: begin
            link_raddr = link_rdata;
            if (elem_match) begin
               // unlink: predecessor takes the successor of the match
               link_we    = 1'b1;
               link_waddr = p_ff;
               link_wdata = link_rdata;
               state_in   = ST_DEL_WR;
            end else if (k_ff == LAST_IDX || link_rdata == '0) begin
               res_in   = make_res('0, 1'b0, STATUS_OK);
               state_in = ST_RESP;
            end else begin
               p_in = t_ff;
               t_in = link_rdata;
               k_in = IDX_BITS'(k_ff + 1'b1);
            end
         end
         ST_DEL_WR: begin
            link_we    = 1'b1;
            link_waddr = t_ff;
            link_wdata = free_ff;
            free_in    = t_ff;
            res_in     = make_res(t_ff, 1'b1, STATUS_OK);
            state_in   = ST_RESP;
         end
         ST_FND_RD: begin
            link_raddr = addr_ff;
            state_in   = ST_FND_CHK;
         end
         ST_FND_CHK: begin
            link_raddr = link_rdata;
            p_in       = link_rdata;
            k_in       = '0;
            if (test_ff) begin
               // is_empty and is_last only look at one link
               res_in   = make_res('0, (link_rdata == '0), STATUS_OK);
               state_in = ST_RESP;
            end else if (link_rdata == '0) begin
               res_in   = make_res('0, 1'b0, STATUS_OK);
               state_in = ST_RESP;
            end else begin
               state_in = ST_FND_CMP;
            end
         end
         ST_FND_CMP: begin
            link_raddr = link_rdata;
            if (elem_match) begin
               res_in   = make_res(p_ff, 1'b0, STATUS_OK);
               state_in = ST_RESP;
            end else if (k_ff == LAST_IDX || link_rdata == '0) begin
               res_in   = make_res('0, 1'b0, STATUS_OK);
               state_in = ST_RESP;
            end else begin
               p_in = link_rdata;
               k_in = IDX_BITS'(k_ff + 1'b1);
            end
         end
         ST_RESP: begin
            if (res_taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         init_ff  <= '0;
         free_ff  <= IDX_BITS'(1);
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      node_ff  <= node_in;
      p_ff     <= p_in;
      t_ff     <= t_in;
      k_ff     <= k_in;
      after_ff <= after_in;
      value_ff <= value_in;
      test_ff  <= test_in;
      res_ff   <= res_in;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign res_valid  = (state_ff == ST_RESP);
   assign res        = res_ff;
   assign elem_waddr = node_ff;
   assign elem_wdata = value_ff;
   assign elem_raddr = link_raddr;

   // node 0 only lives in the free head register once the sweep is over
   `CLLE_ASSERT_IMP(a_no_link_write_node0, clock, reset, link_we && state_ff != ST_INIT, link_waddr != '0)
   `CLLE_ASSERT_NXT(a_free_head_held, clock, reset, state_ff != ST_NEW_WR && state_ff != ST_INS_WR_POS && state_ff != ST_DEL_WR, $stable(free_ff))
   `CLLE_ASSERT_IMP(a_error_result_zero, clock, reset, state_ff == ST_RESP && res_ff.status != STATUS_OK, res_ff.node_index == '0 && !res_ff.flag)
   `CLLE_ASSERT_IMP(a_walk_nonzero, clock, reset, state_ff == ST_FND_CMP || state_ff == ST_DEL_CMP, (state_ff == ST_FND_CMP && p_ff != '0) || (t_ff != '0 && p_ff != '0))

endmodule

@@ src/clle_out.sv @@
// ----------------------------------------------------------------------------
// clle_out
// result register between the sequencer and the result channel
// ----------------------------------------------------------------------------
module clle_out import clle_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   res_valid,
   input  res_type                res,
   output logic                   res_taken,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [NODE_BITS-1:0]   rsp_node_index,
   output logic                   rsp_flag,
   output logic [STATUS_BITS-1:0] rsp_status
);

   logic    valid_ff, valid_in;
   res_type data_ff;

   // slot opens when empty or when the waiting item leaves this cycle
   assign res_taken = res_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      if (res_taken) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_taken) begin
         data_ff <= res;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_node_index = data_ff.node_index;
   assign rsp_flag       = data_ff.flag;
   assign rsp_status     = data_ff.status;

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// checks the cursor linked list engine against a list-pool predictor: a short
// scripted run over error codes, extremes and pool exhaustion, then random
// list traffic under four sender/receiver idle mixes
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import clle_pkg::*;

   // codes the engine leaves unassigned
   localparam logic [OP_BITS-1:0] OP_RSVD_A = 3'd6;
   localparam logic [OP_BITS-1:0] OP_RSVD_B = 3'd7;

   localparam int RANDOM_PER_PHASE = 330;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int SETTLE_CYCLES    = 2 * NODES + 32;
   localparam int REPORT_LIMIT     = 10;
   localparam int MAX_HEADERS      = 5;

   localparam res_type PREDICTED = '0;

   typedef struct {
      logic [OP_BITS-1:0]           op;
      logic signed [VALUE_BITS-1:0] value;
      logic [NODE_BITS-1:0]         head;
      logic [NODE_BITS-1:0]         pos;
      int                           repeats;
      bit                           fixed;
      res_type                      outcome;
   } script_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [OP_BITS-1:0]            req_operation = '0;
   logic signed [VALUE_BITS-1:0]  req_value = '0;
   logic [NODE_BITS-1:0]          req_list_head = '0;
   logic [NODE_BITS-1:0]          req_position = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [NODE_BITS-1:0]          rsp_node_index;
   logic                          rsp_flag;
   logic [STATUS_BITS-1:0]        rsp_status;

   // predictor copy of the node pool
   logic [NODE_BITS-1:0] link_mem [NODES];
   logic [DATA_BITS-1:0] elem_mem [NODES];
   bit                   elem_known [NODES];
   logic [NODE_BITS-1:0] headers_q[$];
   res_type              awaited_answers[$];

   int idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   int idle_plan [4] = '{0, 85, 0, 24};
   int stall_plan [4] = '{0, 0, 85, 24};

   // the insert burst after node 5 takes nodes 6 onward until the pool runs dry
   script_row_type script_rows [24] = '{
      '{OP_IS_EMPTY, 0, 4'd0, 4'd0, 1, 1'b1, '{4'd0, 1'b0, STATUS_BAD_INDEX}},
      '{OP_IS_LAST, 0, 4'd0, 4'd15, 1, 1'b1, '{4'd0, 1'b1, STATUS_OK}},
      '{OP_FIND, 5, 4'd0, 4'd0, 1, 1'b1, '{4'd0, 1'b0, STATUS_BAD_INDEX}},
      '{OP_DELETE, 5, 4'd0, 4'd0, 1, 1'b1, '{4'd0, 1'b0, STATUS_BAD_INDEX}},
      '{OP_INSERT, 5, 4'd0, 4'd0, 1, 1'b1, '{4'd0, 1'b0, STATUS_BAD_INDEX}},
      '{OP_RSVD_A, 0, 4'd0, 4'd0, 1, 1'b1, '{4'd0, 1'b0, STATUS_OK}},
      '{OP_RSVD_B, -1, 4'd15, 4'd15, 1, 1'b1, '{4'd0, 1'b0, STATUS_OK}},
      '{OP_NEW_LIST, 0, 4'd0, 4'd0, 1, 1'b1, '{4'd1, 1'b0, STATUS_OK}},
      '{OP_IS_EMPTY, 0, 4'd1, 4'd0, 1, 1'b1, '{4'd0, 1'b1, STATUS_OK}},
      '{OP_FIND, 5, 4'd1, 4'd0, 1, 1'b1, '{4'd0, 1'b0, STATUS_OK}},
      '{OP_INSERT, 32'sh7fffffff, 4'd0, 4'd1, 1, 1'b1, '{4'd2, 1'b0, STATUS_OK}},
      '{OP_INSERT, 32'sh80000000, 4'd0, 4'd1, 1, 1'b1, '{4'd3, 1'b0, STATUS_OK}},
      '{OP_INSERT, -1, 4'd0, 4'd2, 1, 1'b1, '{4'd4, 1'b0, STATUS_OK}},
      '{OP_INSERT, 0, 4'd0, 4'd4, 1, 1'b1, '{4'd5, 1'b0, STATUS_OK}},
      '{OP_FIND, 32'sh7fffffff, 4'd1, 4'd0, 1, 1'b0, PREDICTED},
      '{OP_DELETE, 32'sh80000000, 4'd1, 4'd0, 1, 1'b0, PREDICTED},
      '{OP_DELETE, 77, 4'd1, 4'd0, 1, 1'b0, PREDICTED},
      '{OP_NEW_LIST, 0, 4'd0, 4'd0, 1, 1'b0, PREDICTED},
      '{OP_INSERT, 9, 4'd0, 4'd5, 10, 1'b0, PREDICTED},
      '{OP_NEW_LIST, 0, 4'd0, 4'd0, 1, 1'b1, '{4'd0, 1'b0, STATUS_POOL_OUT}},
      '{OP_INSERT, 1, 4'd0, 4'd2, 1, 1'b1, '{4'd0, 1'b0, STATUS_POOL_OUT}},
      '{OP_DELETE, 9, 4'd1, 4'd0, 2, 1'b0, PREDICTED},
      '{OP_FIND, 9, 4'd15, 4'd0, 1, 1'b0, PREDICTED},
      '{OP_IS_EMPTY, 0, 4'd15, 4'd0, 1, 1'b0, PREDICTED}
   };

   cursor_linked_list_engine_core u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // every 4-bit index lies inside the 16-node pool, so only node 0 is bad
   function automatic res_type apply_list_op(input logic [OP_BITS-1:0] op,
                                             input logic signed [VALUE_BITS-1:0] value,
                                             input logic [NODE_BITS-1:0] head,
                                             input logic [NODE_BITS-1:0] pos);
      res_type              r;
      logic [DATA_BITS-1:0] key;
      logic [NODE_BITS-1:0] n;
      logic [NODE_BITS-1:0] prev;
      logic [NODE_BITS-1:0] after;
      bit                   hit;
      int                   k;
      r = '0;
      key = DATA_BITS'(value);
      case (op)
         OP_NEW_LIST: begin
            if (link_mem[0] == '0) begin
               r.status = STATUS_POOL_OUT;
            end else begin
               n = link_mem[0];
               link_mem[0] = link_mem[n];
               link_mem[n] = '0;
               r.node_index = n;
               headers_q.push_back(n);
            end
         end
         OP_INSERT: begin
            if (pos == '0) begin
               r.status = STATUS_BAD_INDEX;
            end else if (link_mem[0] == '0) begin
               r.status = STATUS_POOL_OUT;
            end else begin
               after = link_mem[pos];
               n = link_mem[0];
               link_mem[0] = link_mem[n];
               elem_mem[n] = key;
               elem_known[n] = 1'b1;
               link_mem[pos] = n;
               link_mem[n] = after;
               r.node_index = n;
            end
         end
         OP_DELETE: begin
            if (head == '0) begin
               r.status = STATUS_BAD_INDEX;
            end else begin
               prev = head;
               hit = 1'b0;
               for (k = 0; k < NODES; k++) begin
                  if (link_mem[prev] == '0) break;
                  if (elem_mem[link_mem[prev]] == key) begin
                     hit = 1'b1;
                     break;
                  end
                  prev = link_mem[prev];
               end
               if (hit) begin
                  n = link_mem[prev];
                  link_mem[prev] = link_mem[n];
                  link_mem[n] = link_mem[0];
                  link_mem[0] = n;
                  r.node_index = n;
                  r.flag = 1'b1;
               end
            end
         end
         OP_FIND: begin
            if (head == '0) begin
               r.status = STATUS_BAD_INDEX;
            end else begin
               n = link_mem[head];
               k = 0;
               while (n != '0 && elem_mem[n] != key && k < NODES) begin
                  n = link_mem[n];
                  k++;
               end
               r.node_index = (k < NODES) ? n : '0;
            end
         end
         OP_IS_EMPTY: begin
            if (head == '0) r.status = STATUS_BAD_INDEX;
            else r.flag = (link_mem[head] == '0);
         end
         OP_IS_LAST: begin
            if (pos == '0) r.status = STATUS_BAD_INDEX;
            else r.flag = (link_mem[pos] == '0);
         end
         default: ;
      endcase
      return r;
   endfunction

   // a search may only touch elements that were written at some point
   function automatic bit walk_reads_known(input logic [NODE_BITS-1:0] head,
                                           input logic signed [VALUE_BITS-1:0] value);
      logic [NODE_BITS-1:0] n;
      if (head == '0) return 1'b1;
      n = link_mem[head];
      for (int k = 0; k <= NODES; k++) begin
         if (n == '0) return 1'b1;
         if (!elem_known[n]) return 1'b0;
         if (elem_mem[n] == DATA_BITS'(value)) return 1'b1;
         n = link_mem[n];
      end
      return 1'b1;
   endfunction

   function automatic logic [NODE_BITS-1:0] node_along(input logic [NODE_BITS-1:0] head,
                                                        input int steps);
      logic [NODE_BITS-1:0] n;
      n = head;
      for (int k = 0; k < steps; k++) begin
         if (link_mem[n] == '0) break;
         n = link_mem[n];
      end
      return n;
   endfunction

   // small values so searches hit, plus the extremes and full-range noise
   function automatic logic signed [VALUE_BITS-1:0] draw_value();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return $urandom_range(0, 7);
      if (pick == 6) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return -1;
            default: return 0;
         endcase
      end
      return $urandom;
   endfunction

   task automatic make_random_item(output logic [OP_BITS-1:0] op,
                                   output logic signed [VALUE_BITS-1:0] value,
                                   output logic [NODE_BITS-1:0] head,
                                   output logic [NODE_BITS-1:0] pos);
      int                   pick;
      logic [NODE_BITS-1:0] home;
      logic [NODE_BITS-1:0] spot;
      pick = $urandom_range(0, 99);
      if (headers_q.size() != 0) home = headers_q[$urandom_range(0, headers_q.size() - 1)];
      else home = NODE_BITS'($urandom_range(1, NODES - 1));
      head = NODE_BITS'($urandom_range(0, NODES - 1));
      pos = NODE_BITS'($urandom_range(0, NODES - 1));
      value = draw_value();
      op = OP_IS_EMPTY;
      if (pick < 5) begin
         // headers are never given back, so only a handful get made
         if (headers_q.size() < MAX_HEADERS || link_mem[0] == '0) op = OP_NEW_LIST;
      end else if (pick < 40) begin
         op = OP_INSERT;
         pos = node_along(home, $urandom_range(0, NODES));
      end else if (pick < 85) begin
         op = (pick < 65) ? OP_DELETE : OP_FIND;
         head = home;
         spot = node_along(home, $urandom_range(1, NODES));
         if (spot != home && $urandom_range(0, 1)) value = elem_mem[spot];
      end else if (pick < 90) begin
         op = OP_IS_EMPTY;
      end else if (pick < 94) begin
         op = OP_IS_LAST;
      end else if (pick < 96) begin
         op = $urandom_range(0, 1) ? OP_RSVD_A : OP_RSVD_B;
      end else if (pick < 98) begin
         op = OP_INSERT;
      end else begin
         op = $urandom_range(0, 1) ? OP_DELETE : OP_FIND;
      end
      if ((op == OP_DELETE || op == OP_FIND) && !walk_reads_known(head, value))
         op = OP_IS_EMPTY;
   endtask

   task automatic issue_list_op(input logic [OP_BITS-1:0] op,
                                input logic signed [VALUE_BITS-1:0] value,
                                input logic [NODE_BITS-1:0] head,
                                input logic [NODE_BITS-1:0] pos,
                                input bit fixed,
                                input res_type outcome);
      res_type predicted;
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_value <= value;
      req_list_head <= head;
      req_position <= pos;
      do @(posedge clock); while (req_stall);
      predicted = apply_list_op(op, value, head, pos);
      awaited_answers.push_back(fixed ? outcome : predicted);
   endtask

   task automatic drain_answers();
      req_valid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      res_type want;
      if (!reset) begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (awaited_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected item: node %0d flag %0d status %0d",
                           rsp_node_index, rsp_flag, rsp_status);
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_node_index !== want.node_index || rsp_flag !== want.flag ||
                   rsp_status !== want.status) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("mismatch: expected node %0d flag %0d status %0d, %s %0d %0d %0d",
                              want.node_index, want.flag, want.status, "got",
                              rsp_node_index, rsp_flag, rsp_status);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      logic [OP_BITS-1:0]           op;
      logic signed [VALUE_BITS-1:0] value;
      logic [NODE_BITS-1:0]         head;
      logic [NODE_BITS-1:0]         pos;
      for (int i = 0; i < NODES; i++) begin
         link_mem[i] = (i + 1 < NODES) ? NODE_BITS'(i + 1) : '0;
         elem_mem[i] = '0;
         elem_known[i] = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (script_rows[i])
         repeat (script_rows[i].repeats)
            issue_list_op(script_rows[i].op, script_rows[i].value, script_rows[i].head,
                          script_rows[i].pos, script_rows[i].fixed, script_rows[i].outcome);
      drain_answers();

      foreach (idle_plan[p]) begin
         idle_pct = idle_plan[p];
         stall_pct = stall_plan[p];
         repeat (RANDOM_PER_PHASE) begin
            make_random_item(op, value, head, pos);
            issue_list_op(op, value, head, pos, 1'b0, PREDICTED);
         end
         drain_answers();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited_answers.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
